// File: rtl/lhc_pkg.sv
// shared types and constants for the lru hash cache with expiry
// no dependencies; every other file of the block but lhc_ram uses this package
package lhc_pkg;

  localparam int unsigned ENTRIES_DEF  = 1024;
  localparam int unsigned SLOTS_DEF    = 2048;
  localparam int unsigned KEY_BITS_DEF = 64;

  localparam int CMD_W  = 3;
  localparam int HASH_W = 32;
  localparam int TAG_W  = 64;
  localparam int DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 11;

  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EVICT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // controller to datapath strobes
  typedef struct packed {
    logic in_rdy;
    logic slot_we;
    logic ent_we;
    logic ent_used;
    logic ent_new_home;
    logic prev_we;
    logic next_we;
    logic cap;
    logic out_load;
    logic out_ok;
    logic out_hit;
  } lhc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             in_fire;
    logic             out_free;
    logic             key_valid;
    logic [CMD_W-1:0] command;
    logic             rd_used;
    logic             rd_hit;
    logic             rd_expired;
  } lhc_stat_t;

endpackage

// File: rtl/lhc_in_if.sv
// input word channel of the cache: valid/ready plus the command fields
// depends on lhc_pkg
interface lhc_in_if;
  logic                         valid;
  logic                         ready;
  logic [lhc_pkg::CMD_W-1:0]    command;
  logic                         key_valid;
  logic [lhc_pkg::HASH_W-1:0]   key_hash;
  logic [lhc_pkg::TAG_W-1:0]    key_tag;
  logic [lhc_pkg::DATA_W-1:0]   value_data;
  logic [lhc_pkg::TIME_W-1:0]   expiry_time;
  logic [lhc_pkg::TIME_W-1:0]   now_seconds;

  modport source (output valid, command, key_valid, key_hash, key_tag, value_data,
                  expiry_time, now_seconds, input ready);
  modport sink   (input valid, command, key_valid, key_hash, key_tag, value_data,
                  expiry_time, now_seconds, output ready);
endinterface

// File: rtl/lhc_out_if.sv
// result word channel of the cache: valid/ready plus the result fields
// depends on lhc_pkg
interface lhc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [lhc_pkg::DATA_W-1:0]  value_out;
  logic [lhc_pkg::TIME_W-1:0]  expiry_out;
  logic [lhc_pkg::CNT_W-1:0]   evicted_count;

  modport source (output valid, success, value_out, expiry_out, evicted_count,
                  input ready);
  modport sink   (input valid, success, value_out, expiry_out, evicted_count,
                  output ready);
endinterface

// File: rtl/lru_hash_cache_with_expiry.sv
// top level of the lru hash cache with expiry: controller plus datapath
// depends on lhc_pkg, lhc_in_if, lhc_out_if, lhc_ctrl, lhc_dpath
//
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+-------------------------------------------
//  in_ch    | in  | valid/ready       | command, key, hash, payload, expiry, now
//  out_ch   | out | valid/ready       | success, value, expiry, evicted count
//
// one command at a time; the next word is taken while a result waits in the output register
// lookup/contains/remove: accept, dispatch and result, plus the probe chain walk that reads
//   each slot and compares each key, plus the move to front, or to free the entry a walk of
//   its home probe chain; the single port slot memory reads one probe slot at a time
// insert of a new key adds the free-list pop and an empty-slot probe, evict walks every
//   entry and frees each expired one, clear sweeps every slot and entry address
// after reset the same sweep runs before the first word is accepted
// a stalled output only holds the result; nothing is dropped
module lru_hash_cache_with_expiry #(
  parameter int unsigned ENTRIES  = lhc_pkg::ENTRIES_DEF,
  parameter int unsigned SLOTS    = lhc_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = lhc_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lhc_in_if.sink    in_ch,
  lhc_out_if.source out_ch
);
  import lhc_pkg::*;

  // index width carries entry numbers plus the empty and tombstone codes
  localparam int unsigned IW  = $clog2(ENTRIES + 2);
  localparam int unsigned EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SAW = $clog2(SLOTS);

  lhc_cmd_t        cmd;
  lhc_stat_t       stat;
  logic [SAW-1:0]  slot_addr;
  logic [IW-1:0]   slot_wdata;
  logic [IW-1:0]   slot_rd;
  logic [EAW-1:0]  ent_addr;
  logic [EAW-1:0]  prev_addr;
  logic [IW-1:0]   prev_wdata;
  logic [IW-1:0]   prev_rd;
  logic [EAW-1:0]  next_addr;
  logic [IW-1:0]   next_wdata;
  logic [IW-1:0]   next_rd;
  logic [CNT_W-1:0] out_cnt;
  logic [SAW-1:0]  item_home;
  logic [SAW-1:0]  cap_home;

  // sequencer: probe walk, list surgery, free list, evict scan, clear sweep
  lhc_ctrl #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rd    (slot_rd),
    .ent_addr   (ent_addr),
    .prev_addr  (prev_addr),
    .prev_wdata (prev_wdata),
    .prev_rd    (prev_rd),
    .next_addr  (next_addr),
    .next_wdata (next_wdata),
    .next_rd    (next_rd),
    .out_cnt    (out_cnt),
    .item_home  (item_home),
    .cap_home   (cap_home)
  );

  // memories, word registers, compares and the result register
  lhc_dpath #(.ENTRIES(ENTRIES), .SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cmd        (cmd),
    .stat       (stat),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rd    (slot_rd),
    .ent_addr   (ent_addr),
    .prev_addr  (prev_addr),
    .prev_wdata (prev_wdata),
    .prev_rd    (prev_rd),
    .next_addr  (next_addr),
    .next_wdata (next_wdata),
    .next_rd    (next_rd),
    .out_cnt    (out_cnt),
    .item_home  (item_home),
    .cap_home   (cap_home)
  );

endmodule

// File: rtl/lhc_ram.sv
// generic single port ram with registered read data, read before write
// no dependencies
module lhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lhc_dpath.sv
// datapath: word registers, slot/entry/link memories, key and expiry compare, result register
// depends on lhc_pkg, lhc_in_if, lhc_out_if, lhc_ram
module lhc_dpath #(
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned SLOTS    = 2048,
  parameter int unsigned KEY_BITS = 64,
  localparam int unsigned IW  = $clog2(ENTRIES + 2),
  localparam int unsigned EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned SAW = $clog2(SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lhc_in_if.sink                    in_ch,
  lhc_out_if.source                 out_ch,
  input  lhc_pkg::lhc_cmd_t         cmd,
  output lhc_pkg::lhc_stat_t        stat,
  input  logic [SAW-1:0]            slot_addr,
  input  logic [IW-1:0]             slot_wdata,
  output logic [IW-1:0]             slot_rd,
  input  logic [EAW-1:0]            ent_addr,
  input  logic [EAW-1:0]            prev_addr,
  input  logic [IW-1:0]             prev_wdata,
  output logic [IW-1:0]             prev_rd,
  input  logic [EAW-1:0]            next_addr,
  input  logic [IW-1:0]             next_wdata,
  output logic [IW-1:0]             next_rd,
  input  logic [lhc_pkg::CNT_W-1:0] out_cnt,
  output logic [SAW-1:0]            item_home,
  output logic [SAW-1:0]            cap_home
);
  import lhc_pkg::*;

  // entry word: used, home slot, expiry, payload, key
  localparam int unsigned EW = 1 + SAW + TIME_W + DATA_W + KEY_BITS;

  logic [CMD_W-1:0]    cmd_r;
  logic                kv_r;
  logic [HASH_W-1:0]   hash_r;
  logic [KEY_BITS-1:0] tag_r;
  logic [DATA_W-1:0]   val_r;
  logic [TIME_W-1:0]   exp_r;
  logic [TIME_W-1:0]   now_r;

  logic [EW-1:0]       ent_rd;
  logic [EW-1:0]       ent_wdata;
  logic [EW-1:0]       cap_r;

  logic                out_valid_r;
  logic                out_ok_r;
  logic [DATA_W-1:0]   out_val_r;
  logic [TIME_W-1:0]   out_exp_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic                in_fire;
  logic                rd_used;
  logic [KEY_BITS-1:0] rd_key;
  logic [TIME_W-1:0]   rd_exp;

  assign in_ch.ready = cmd.in_rdy;
  assign in_fire     = in_ch.valid && cmd.in_rdy;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.command;
      kv_r   <= in_ch.key_valid;
      hash_r <= in_ch.key_hash;
      tag_r  <= in_ch.key_tag[KEY_BITS-1:0];
      val_r  <= in_ch.value_data;
      exp_r  <= in_ch.expiry_time;
      now_r  <= in_ch.now_seconds;
    end
    if (cmd.cap) begin
      cap_r <= ent_rd;
    end
  end

  assign item_home = hash_r[SAW-1:0];
  assign cap_home  = cap_r[EW-2 -: SAW];

  assign rd_used = ent_rd[EW-1];
  assign rd_exp  = ent_rd[KEY_BITS+DATA_W +: TIME_W];
  assign rd_key  = ent_rd[KEY_BITS-1:0];

  always_comb begin
    if (cmd.ent_used) begin
      ent_wdata = {1'b1, (cmd.ent_new_home ? item_home : cap_home), exp_r, val_r, tag_r};
    end else begin
      ent_wdata = {1'b0, cap_r[EW-2:0]};
    end
  end

  lhc_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_slot (
    .clk(clk), .we(cmd.slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rd)
  );

  lhc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ent (
    .clk(clk), .we(cmd.ent_we), .addr(ent_addr), .wdata(ent_wdata), .rdata(ent_rd)
  );

  lhc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev (
    .clk(clk), .we(cmd.prev_we), .addr(prev_addr), .wdata(prev_wdata), .rdata(prev_rd)
  );

  lhc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next (
    .clk(clk), .we(cmd.next_we), .addr(next_addr), .wdata(next_wdata), .rdata(next_rd)
  );

  assign stat.in_fire    = in_fire;
  assign stat.out_free   = !out_valid_r || out_ch.ready;
  assign stat.key_valid  = kv_r;
  assign stat.command    = cmd_r;
  assign stat.rd_used    = rd_used;
  assign stat.rd_hit     = rd_used && (rd_key == tag_r);
  assign stat.rd_expired = rd_exp <= now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r  <= cmd.out_ok;
      out_val_r <= cmd.out_hit ? cap_r[KEY_BITS +: DATA_W] : '0;
      out_exp_r <= cmd.out_hit ? cap_r[KEY_BITS+DATA_W +: TIME_W] : '0;
      out_cnt_r <= out_cnt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.success       = out_ok_r;
  assign out_ch.value_out     = out_val_r;
  assign out_ch.expiry_out    = out_exp_r;
  assign out_ch.evicted_count = out_cnt_r;

endmodule

// File: rtl/lhc_ctrl.sv
// controller: command sequencer, probe and scan counters, free list and recency list heads
// depends on lhc_pkg
module lhc_ctrl #(
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned SLOTS    = 2048,
  localparam int unsigned IW  = $clog2(ENTRIES + 2),
  localparam int unsigned EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned SAW = $clog2(SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output lhc_pkg::lhc_cmd_t         cmd,
  input  lhc_pkg::lhc_stat_t        stat,
  output logic [SAW-1:0]            slot_addr,
  output logic [IW-1:0]             slot_wdata,
  input  logic [IW-1:0]             slot_rd,
  output logic [EAW-1:0]            ent_addr,
  output logic [EAW-1:0]            prev_addr,
  output logic [IW-1:0]             prev_wdata,
  input  logic [IW-1:0]             prev_rd,
  output logic [EAW-1:0]            next_addr,
  output logic [IW-1:0]             next_wdata,
  input  logic [IW-1:0]             next_rd,
  output logic [lhc_pkg::CNT_W-1:0] out_cnt,
  input  logic [SAW-1:0]            item_home,
  input  logic [SAW-1:0]            cap_home
);
  import lhc_pkg::*;

  localparam int unsigned MAXD = (SLOTS > ENTRIES) ? SLOTS : ENTRIES;
  localparam int unsigned SW   = $clog2(MAXD);
  localparam logic [IW-1:0]  NIL  = IW'(ENTRIES);
  localparam logic [IW-1:0]  TOMB = IW'(ENTRIES + 1);
  localparam logic [EAW-1:0] SCAN_LAST = EAW'(ENTRIES - 1);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_FSLOT = 5'd3;
  localparam logic [4:0] S_FENT  = 5'd4;
  localparam logic [4:0] S_NOTF  = 5'd5;
  localparam logic [4:0] S_TL    = 5'd6;
  localparam logic [4:0] S_AL0   = 5'd7;
  localparam logic [4:0] S_AL1   = 5'd8;
  localparam logic [4:0] S_AP    = 5'd9;
  localparam logic [4:0] S_INSU  = 5'd10;
  localparam logic [4:0] S_MF0   = 5'd11;
  localparam logic [4:0] S_MF1   = 5'd12;
  localparam logic [4:0] S_MF2   = 5'd13;
  localparam logic [4:0] S_MF3   = 5'd14;
  localparam logic [4:0] S_FR0   = 5'd15;
  localparam logic [4:0] S_FR1   = 5'd16;
  localparam logic [4:0] S_FR2   = 5'd17;
  localparam logic [4:0] S_EV1   = 5'd18;
  localparam logic [4:0] S_EV2   = 5'd19;
  localparam logic [4:0] S_RESP  = 5'd20;

  logic [4:0]     st_r, st_nxt, ret_r, ret_nxt;
  logic [SAW-1:0] s_r, s_nxt, probe_r, probe_nxt;
  logic [IW-1:0]  e_r, e_nxt;
  logic [IW-1:0]  free_head_r, free_head_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [IW-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EAW-1:0] scan_r, scan_nxt;
  logic [SW-1:0]  sweep_r, sweep_nxt;
  logic           clr_resp_r, clr_resp_nxt;
  logic           rsp_ok_r, rsp_ok_nxt, rsp_hit_r, rsp_hit_nxt;

  // shared step helpers
  logic           adv, unl;
  logic [4:0]     adv_loop_st, adv_done_st;

  assign out_cnt = cnt_r;

  always_comb begin
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    s_nxt         = s_r;
    probe_nxt     = probe_r;
    e_nxt         = e_r;
    free_head_nxt = free_head_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    live_nxt      = live_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    sweep_nxt     = sweep_r;
    clr_resp_nxt  = clr_resp_r;
    rsp_ok_nxt    = rsp_ok_r;
    rsp_hit_nxt   = rsp_hit_r;
    cmd           = '0;
    slot_addr     = s_r;
    slot_wdata    = NIL;
    ent_addr      = e_r[EAW-1:0];
    prev_addr     = e_r[EAW-1:0];
    prev_wdata    = NIL;
    next_addr     = e_r[EAW-1:0];
    next_wdata    = NIL;
    adv           = 1'b0;
    unl           = 1'b0;
    adv_loop_st   = st_r;
    adv_done_st   = st_r;

    case (st_r)
      S_CLR: begin
        // one slot and one entry per cycle
        slot_addr    = SAW'(sweep_r);
        ent_addr     = EAW'(sweep_r);
        prev_addr    = EAW'(sweep_r);
        next_addr    = EAW'(sweep_r);
        cmd.slot_we  = int'(sweep_r) < int'(SLOTS);
        cmd.ent_we   = int'(sweep_r) < int'(ENTRIES);
        cmd.prev_we  = int'(sweep_r) < int'(ENTRIES);
        cmd.next_we  = int'(sweep_r) < int'(ENTRIES);
        next_wdata   = (int'(sweep_r) + 1 < int'(ENTRIES)) ? IW'(int'(sweep_r) + 1) : NIL;
        if (int'(sweep_r) == int'(MAXD) - 1) begin
          free_head_nxt = '0;
          head_nxt      = NIL;
          tail_nxt      = NIL;
          live_nxt      = '0;
          clr_resp_nxt  = 1'b0;
          st_nxt        = clr_resp_r ? S_RESP : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (stat.in_fire) begin
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        rsp_ok_nxt  = 1'b0;
        rsp_hit_nxt = 1'b0;
        cnt_nxt     = '0;
        if ((stat.command == CMD_LOOKUP || stat.command == CMD_CONTAINS ||
             stat.command == CMD_INSERT || stat.command == CMD_REMOVE) && stat.key_valid) begin
          slot_addr = item_home;
          s_nxt     = item_home;
          probe_nxt = '0;
          st_nxt    = S_FSLOT;
        end else if (stat.command == CMD_EVICT) begin
          ent_addr = '0;
          scan_nxt = '0;
          st_nxt   = S_EV1;
        end else if (stat.command == CMD_CLEAR) begin
          sweep_nxt    = '0;
          clr_resp_nxt = 1'b1;
          st_nxt       = S_CLR;
        end else begin
          st_nxt = S_RESP;
        end
      end
      S_FSLOT: begin
        if (slot_rd == NIL) begin
          st_nxt = S_NOTF;
        end else if (slot_rd < NIL) begin
          e_nxt    = slot_rd;
          ent_addr = slot_rd[EAW-1:0];
          st_nxt   = S_FENT;
        end else begin
          adv         = 1'b1;
          adv_loop_st = S_FSLOT;
          adv_done_st = S_NOTF;
        end
      end
      S_FENT: begin
        if (stat.rd_hit) begin
          cmd.cap = 1'b1;
          case (stat.command)
            CMD_LOOKUP, CMD_CONTAINS: begin
              if (stat.rd_expired) begin
                ret_nxt = S_RESP;
                st_nxt  = (stat.command == CMD_LOOKUP) ? S_FR0 : S_RESP;
              end else begin
                rsp_ok_nxt  = 1'b1;
                rsp_hit_nxt = 1'b1;
                st_nxt      = (stat.command == CMD_LOOKUP) ? S_MF0 : S_RESP;
              end
            end
            CMD_INSERT: begin
              rsp_ok_nxt = 1'b1;
              st_nxt     = S_INSU;
            end
            default: begin
              rsp_ok_nxt = 1'b1;
              ret_nxt    = S_RESP;
              st_nxt     = S_FR0;
            end
          endcase
        end else begin
          adv         = 1'b1;
          adv_loop_st = S_FSLOT;
          adv_done_st = S_NOTF;
        end
      end
      S_NOTF: begin
        if (stat.command == CMD_INSERT) begin
          if (free_head_r != NIL) begin
            st_nxt = S_AL0;
          end else if (tail_r < NIL) begin
            // store full: drop the least recent entry first
            e_nxt    = tail_r;
            ent_addr = tail_r[EAW-1:0];
            st_nxt   = S_TL;
          end else begin
            st_nxt = S_RESP;
          end
        end else begin
          st_nxt = S_RESP;
        end
      end
      S_TL: begin
        cmd.cap = 1'b1;
        ret_nxt = S_AL0;
        st_nxt  = S_FR0;
      end
      S_AL0: begin
        e_nxt     = free_head_r;
        next_addr = free_head_r[EAW-1:0];
        st_nxt    = S_AL1;
      end
      S_AL1: begin
        free_head_nxt    = next_rd;
        cmd.ent_we       = 1'b1;
        cmd.ent_used     = 1'b1;
        cmd.ent_new_home = 1'b1;
        slot_addr        = item_home;
        s_nxt            = item_home;
        probe_nxt        = '0;
        live_nxt         = live_r + 1'b1;
        rsp_ok_nxt       = 1'b1;
        st_nxt           = S_AP;
      end
      S_AP: begin
        if (slot_rd == NIL || slot_rd == TOMB) begin
          cmd.slot_we = 1'b1;
          slot_addr   = s_r;
          slot_wdata  = e_r;
          st_nxt      = S_MF2;
        end else begin
          // slot table full leaves the entry unplaced
          adv         = 1'b1;
          adv_loop_st = S_AP;
          adv_done_st = S_MF2;
        end
      end
      S_INSU: begin
        cmd.ent_we   = 1'b1;
        cmd.ent_used = 1'b1;
        st_nxt       = S_MF1;
      end
      S_MF0: begin
        st_nxt = S_MF1;
      end
      S_MF1: begin
        unl    = 1'b1;
        st_nxt = S_MF2;
      end
      S_MF2: begin
        cmd.next_we = 1'b1;
        next_wdata  = head_r;
        if (head_r < NIL) begin
          cmd.prev_we = 1'b1;
          prev_addr   = head_r[EAW-1:0];
          prev_wdata  = e_r;
        end
        head_nxt = e_r;
        if (tail_r >= NIL) begin
          tail_nxt = e_r;
        end
        st_nxt = S_MF3;
      end
      S_MF3: begin
        cmd.prev_we = 1'b1;
        st_nxt      = S_RESP;
      end
      S_FR0: begin
        cmd.ent_we = 1'b1;
        st_nxt     = S_FR1;
      end
      S_FR1: begin
        unl       = 1'b1;
        slot_addr = cap_home;
        s_nxt     = cap_home;
        probe_nxt = '0;
        st_nxt    = S_FR2;
      end
      S_FR2: begin
        if (slot_rd == NIL || slot_rd == e_r || probe_r == '1) begin
          if (slot_rd == e_r) begin
            cmd.slot_we = 1'b1;
            slot_addr   = s_r;
            slot_wdata  = TOMB;
          end
          cmd.next_we   = 1'b1;
          next_wdata    = free_head_r;
          cmd.prev_we   = 1'b1;
          free_head_nxt = e_r;
          if (live_r != '0) begin
            live_nxt = live_r - 1'b1;
          end
          st_nxt = ret_r;
        end else begin
          s_nxt     = s_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          slot_addr = s_r + 1'b1;
        end
      end
      S_EV1: begin
        if (stat.rd_used && stat.rd_expired) begin
          cmd.cap = 1'b1;
          e_nxt   = IW'(scan_r);
          ret_nxt = S_EV2;
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          st_nxt = S_FR0;
        end else begin
          st_nxt = S_EV2;
        end
      end
      S_EV2: begin
        if (scan_r == SCAN_LAST) begin
          st_nxt = S_RESP;
        end else begin
          scan_nxt = scan_r + 1'b1;
          ent_addr = scan_r + 1'b1;
          st_nxt   = S_EV1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = rsp_ok_r;
          cmd.out_hit  = rsp_hit_r;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // unlink e from the recency list, prev/next were read the cycle before
    if (unl) begin
      if (prev_rd < NIL) begin
        cmd.next_we = 1'b1;
        next_addr   = prev_rd[EAW-1:0];
        next_wdata  = next_rd;
      end else begin
        head_nxt = next_rd;
      end
      if (next_rd < NIL) begin
        cmd.prev_we = 1'b1;
        prev_addr   = next_rd[EAW-1:0];
        prev_wdata  = prev_rd;
      end else begin
        tail_nxt = prev_rd;
      end
    end

    // linear probe step
    if (adv) begin
      if (probe_r == '1) begin
        st_nxt = adv_done_st;
      end else begin
        st_nxt    = adv_loop_st;
        s_nxt     = s_r + 1'b1;
        probe_nxt = probe_r + 1'b1;
        slot_addr = s_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      ret_r       <= S_IDLE;
      sweep_r     <= '0;
      clr_resp_r  <= 1'b0;
      free_head_r <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      live_r      <= '0;
      cnt_r       <= '0;
      rsp_ok_r    <= 1'b0;
      rsp_hit_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      sweep_r     <= sweep_nxt;
      clr_resp_r  <= clr_resp_nxt;
      free_head_r <= free_head_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      live_r      <= live_nxt;
      cnt_r       <= cnt_nxt;
      rsp_ok_r    <= rsp_ok_nxt;
      rsp_hit_r   <= rsp_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    probe_r <= probe_nxt;
    e_r     <= e_nxt;
    scan_r  <= scan_nxt;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= IW'(ENTRIES))
    else $error("live count above store size");

  a_free_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == NIL) |-> (live_r == IW'(ENTRIES)))
    else $error("free list empty with store not full");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (tail_r == NIL))
    else $error("recency list head and tail disagree");

endmodule

// File: tb/lru_hash_cache_with_expiry_tb.sv
// testbench for lru_hash_cache_with_expiry: directed table and random traffic
// depends on lhc_pkg, lhc_in_if, lhc_out_if and the block itself; results checked by a cache model or a typed row
module lru_hash_cache_with_expiry_tb;
  import lhc_pkg::*;

  localparam int NENT  = 1024;
  localparam int NSLOT = 2048;
  localparam int LIMIT = 1_500_000;
  localparam logic [10:0] NIL     = 11'd1024;
  localparam logic [10:0] S_EMPTY = 11'd1024;
  localparam logic [10:0] S_TOMB  = 11'd1025;
  localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

  typedef struct {
    bit [CMD_W-1:0]  cmd;
    bit              kv;
    bit [HASH_W-1:0] hash;
    bit [TAG_W-1:0]  tag;
    bit [DATA_W-1:0] val;
    bit [TIME_W-1:0] expt;
    bit [TIME_W-1:0] now;
  } cache_req_t;

  typedef struct {
    bit              ok;
    bit [DATA_W-1:0] val;
    bit [TIME_W-1:0] expt;
    bit [CNT_W-1:0]  cnt;
  } cache_resp_t;

  // directed row: typed marks an answer written out by hand
  typedef struct {
    cache_req_t  req;
    bit          typed;
    cache_resp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lhc_in_if  in_if();
  lhc_out_if out_if();

  lru_hash_cache_with_expiry u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cache model: slot table with linear probing, entry store, free list, lru list
  // ---------------------------------------------------------------------------
  logic [10:0] slot_tab [NSLOT];
  bit [63:0]   ent_key  [NENT];
  bit [31:0]   ent_val  [NENT];
  bit [31:0]   ent_exp  [NENT];
  bit [10:0]   ent_home [NENT];
  bit          ent_used [NENT];
  logic [10:0] lru_prev [NENT];
  logic [10:0] lru_next [NENT];
  logic [10:0] free_hd, mru_hd, lru_tl;
  int          live_cnt;

  cache_resp_t resp_q[$];
  int errors = 0;
  int cycles = 0;
  bit press_req = 1'b0;

  function automatic void cache_reset();
    for (int i = 0; i < NSLOT; i++) slot_tab[i] = S_EMPTY;
    for (int i = 0; i < NENT; i++) begin
      ent_key[i] = '0;
      ent_val[i] = '0;
      ent_exp[i] = '0;
      ent_home[i] = '0;
      ent_used[i] = 1'b0;
      lru_prev[i] = NIL;
      lru_next[i] = (i + 1 < NENT) ? 11'(i + 1) : NIL;
    end
    free_hd = '0;
    mru_hd = NIL;
    lru_tl = NIL;
    live_cnt = 0;
  endfunction

  function automatic void lru_unlink(logic [10:0] e);
    logic [10:0] p, n;
    p = lru_prev[e];
    n = lru_next[e];
    if (p < NENT) lru_next[p] = n; else mru_hd = n;
    if (n < NENT) lru_prev[n] = p; else lru_tl = p;
    lru_prev[e] = NIL;
    lru_next[e] = NIL;
  endfunction

  function automatic void lru_push(logic [10:0] e);
    lru_prev[e] = NIL;
    lru_next[e] = mru_hd;
    if (mru_hd < NENT) lru_prev[mru_hd] = e;
    mru_hd = e;
    if (lru_tl >= NENT) lru_tl = e;
  endfunction

  function automatic logic [10:0] find_key(bit [31:0] hash, bit [63:0] tag);
    logic [10:0] s, c;
    s = hash[10:0];
    for (int p = 0; p < NSLOT; p++) begin
      c = slot_tab[s];
      if (c == S_EMPTY) return NIL;
      if (c < NENT && ent_used[c] && ent_key[c] == tag) return c;
      s = s + 11'd1;
    end
    return NIL;
  endfunction

  function automatic void release_entry(logic [10:0] e);
    logic [10:0] s, c;
    if (e >= NENT || !ent_used[e]) return;
    ent_used[e] = 1'b0;
    lru_unlink(e);
    s = ent_home[e];
    for (int p = 0; p < NSLOT; p++) begin
      c = slot_tab[s];
      if (c == S_EMPTY) break;
      if (c == e) begin
        slot_tab[s] = S_TOMB;
        break;
      end
      s = s + 11'd1;
    end
    ent_key[e] = '0;
    ent_val[e] = '0;
    ent_exp[e] = '0;
    lru_next[e] = free_hd;
    lru_prev[e] = NIL;
    free_hd = e;
    if (live_cnt > 0) live_cnt--;
  endfunction

  function automatic cache_resp_t cache_apply(cache_req_t r);
    cache_resp_t o;
    logic [10:0] e, s;
    o = '{default: '0};
    if (r.cmd <= CMD_REMOVE && r.kv) begin
      e = find_key(r.hash, r.tag);
      if (r.cmd == CMD_LOOKUP || r.cmd == CMD_CONTAINS) begin
        if (e < NENT) begin
          if (ent_exp[e] <= r.now) begin
            if (r.cmd == CMD_LOOKUP) release_entry(e);
          end else begin
            o.ok = 1'b1;
            o.val = ent_val[e];
            o.expt = ent_exp[e];
            if (r.cmd == CMD_LOOKUP) begin
              lru_unlink(e);
              lru_push(e);
            end
          end
        end
      end else if (r.cmd == CMD_INSERT) begin
        if (e < NENT) begin
          ent_val[e] = r.val;
          ent_exp[e] = r.expt;
          ent_key[e] = r.tag;
          lru_unlink(e);
          lru_push(e);
          o.ok = 1'b1;
        end else begin
          // full store: drop the least recent entry first
          if (free_hd >= NENT && lru_tl < NENT) release_entry(lru_tl);
          if (free_hd < NENT) begin
            e = free_hd;
            free_hd = lru_next[e];
            lru_prev[e] = NIL;
            lru_next[e] = NIL;
            ent_key[e] = r.tag;
            ent_val[e] = r.val;
            ent_exp[e] = r.expt;
            ent_home[e] = r.hash[10:0];
            ent_used[e] = 1'b1;
            s = r.hash[10:0];
            for (int p = 0; p < NSLOT; p++) begin
              if (slot_tab[s] == S_EMPTY || slot_tab[s] == S_TOMB) begin
                slot_tab[s] = e;
                break;
              end
              s = s + 11'd1;
            end
            lru_push(e);
            live_cnt++;
            o.ok = 1'b1;
          end
        end
      end else begin
        if (e < NENT) begin
          release_entry(e);
          o.ok = 1'b1;
        end
      end
    end else if (r.cmd == CMD_EVICT) begin
      // scan from entry 0 upward, count saturates
      for (int i = 0; i < NENT; i++) begin
        if (ent_used[i] && ent_exp[i] <= r.now) begin
          release_entry(11'(i));
          if (o.cnt != CNT_MAX) o.cnt++;
        end
      end
    end else if (r.cmd == CMD_CLEAR) begin
      cache_reset();
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one word, wait for the handshake, then log what the cache should answer
  task automatic send_req(input cache_req_t r, input bit typed, input cache_resp_t want);
    cache_resp_t got;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= r.cmd;
    in_if.key_valid   <= r.kv;
    in_if.key_hash    <= r.hash;
    in_if.key_tag     <= r.tag;
    in_if.value_data  <= r.val;
    in_if.expiry_time <= r.expt;
    in_if.now_seconds <= r.now;
    do @(posedge clk); while (!in_if.ready);
    got = cache_apply(r);
    resp_q.push_back(typed ? want : got);
  endtask

  task automatic send_plain(input cache_req_t r);
    send_req(r, 1'b0, '{default: '0});
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    bit press_done;
    int r;
    hold = 0;
    press_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (press_req && !press_done) begin
        press_done = 1'b1;
        hold = 400;
        out_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          hold = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 60);
        end
      end
    end
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  // result check against the oldest pending answer
  always @(posedge clk) begin
    cache_resp_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (resp_q.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        w = resp_q.pop_front();
        if (out_if.success !== w.ok)
          report($sformatf("success %0b want %0b", out_if.success, w.ok));
        if (out_if.value_out !== w.val)
          report($sformatf("value_out %h want %h", out_if.value_out, w.val));
        if (out_if.expiry_out !== w.expt)
          report($sformatf("expiry_out %h want %h", out_if.expiry_out, w.expt));
        if (out_if.evicted_count !== w.cnt)
          report($sformatf("evicted_count %0d want %0d", out_if.evicted_count, w.cnt));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("lru_hash_cache_with_expiry_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  bit [31:0] pool_hash [48];
  bit [63:0] pool_tag  [48];

  function automatic cache_req_t mk(bit [2:0] c, bit kv, bit [31:0] h, bit [63:0] t,
                                    bit [31:0] v, bit [31:0] x, bit [31:0] n);
    cache_req_t r;
    r.cmd = c; r.kv = kv; r.hash = h; r.tag = t;
    r.val = v; r.expt = x; r.now = n;
    return r;
  endfunction

  function automatic cache_resp_t rs(bit ok, bit [31:0] v, bit [31:0] x, bit [10:0] n);
    cache_resp_t o;
    o.ok = ok; o.val = v; o.expt = x; o.cnt = n;
    return o;
  endfunction

  initial begin
    dir_row_t    rows[$];
    cache_req_t  r;
    bit [63:0]   k0, k1, k2, k4;
    bit [31:0]   now_t;
    int          pick, sel;

    in_if.valid <= 1'b0;
    in_if.command <= CMD_LOOKUP;
    in_if.key_valid <= 1'b0;
    in_if.key_hash <= '0;
    in_if.key_tag <= '0;
    in_if.value_data <= '0;
    in_if.expiry_time <= '0;
    in_if.now_seconds <= '0;
    cache_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    k0 = {$urandom, $urandom};
    k1 = {$urandom, $urandom};
    k2 = {$urandom, $urandom};
    k4 = {$urandom, $urandom};

    // directed table; k0 and k1 share a home slot, the all-ones key and k4 wrap at the top of the table
    rows = '{
      '{mk(CMD_LOOKUP, 1, 32'h5, k0, 0, 0, 0), 1, rs(0, 0, 0, 0)},             // empty cache
      '{mk(CMD_EVICT, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, 32'h5, k0, '1, '1, 0), 1, rs(1, 0, 0, 0)},
      '{mk(CMD_LOOKUP, 1, 32'h5, k0, 0, 0, 0), 1, rs(1, '1, '1, 0)},
      '{mk(CMD_CONTAINS, 1, 32'hFFFF_F805, k1, 0, 0, 0), 1, rs(0, 0, 0, 0)},   // collision miss
      '{mk(CMD_INSERT, 1, 32'hFFFF_F805, k1, 0, 10, 0), 1, rs(1, 0, 0, 0)},
      '{mk(CMD_CONTAINS, 1, 32'hFFFF_F805, k1, 0, 0, 5), 1, rs(1, 0, 10, 0)},
      '{mk(CMD_CONTAINS, 1, 32'hFFFF_F805, k1, 0, 0, 10), 1, rs(0, 0, 0, 0)},  // expired, kept
      '{mk(CMD_LOOKUP, 1, 32'hFFFF_F805, k1, 0, 0, 10), 1, rs(0, 0, 0, 0)},    // expired, freed
      '{mk(CMD_CONTAINS, 1, 32'hFFFF_F805, k1, 0, 0, 0), 0, rs(0, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, 32'h5, k0, 5, 20, 0), 0, rs(0, 0, 0, 0)},            // update in place
      '{mk(CMD_INSERT, 1, 32'h8000_0005, k2, 7, 3, 0), 0, rs(0, 0, 0, 0)},
      '{mk(CMD_REMOVE, 1, 32'h8000_0005, k2, 0, 0, 100), 1, rs(1, 0, 0, 0)},   // expired remove
      '{mk(CMD_REMOVE, 1, 32'h8000_0005, k2, 0, 0, 100), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_INSERT, 0, 32'h5, k0, 9, 9, 0), 1, rs(0, 0, 0, 0)},             // invalid key
      '{mk(CMD_LOOKUP, 0, 32'h5, k0, 0, 0, 0), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_BAD6, 1, 32'h5, k0, 0, 0, 0), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_BAD7, 1, '1, '1, '1, '1, '1), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, '1, '1, 32'hA5A5_5A5A, 50, 0), 1, rs(1, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, 32'h7FF, k4, 32'h1234_5678, 1000, 0), 0, rs(0, 0, 0, 0)},
      '{mk(CMD_EVICT, 0, 0, 0, 0, 0, 50), 1, rs(0, 0, 0, 2)},                  // k0 and all-ones key
      '{mk(CMD_LOOKUP, 1, 32'h7FF, k4, 0, 0, 50), 1, rs(1, 32'h1234_5678, 1000, 0)},
      '{mk(CMD_CLEAR, 1, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)},
      '{mk(CMD_LOOKUP, 1, 32'h7FF, k4, 0, 0, 50), 1, rs(0, 0, 0, 0)}
    };
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);

    // key pool clustered on a few home slots, two of them at the wrap point
    foreach (pool_tag[i]) begin
      sel = $urandom_range(0, 5);
      pool_tag[i] = {$urandom, $urandom};
      pool_hash[i] = $urandom;
      case (sel)
        0: pool_hash[i][10:0] = 11'd0;
        1: pool_hash[i][10:0] = 11'd1;
        2: pool_hash[i][10:0] = 11'd2;
        3: pool_hash[i][10:0] = 11'd2046;
        4: pool_hash[i][10:0] = 11'd2047;
        default: pool_hash[i][10:0] = 11'd1000;
      endcase
    end

    press_req = 1'b1;
    now_t = 32'd100;
    for (int n = 0; n < 526; n++) begin
      pick = $urandom_range(0, 47);
      now_t = now_t + $urandom_range(0, 3);
      if ($urandom_range(0, 99) == 0) now_t = $urandom;
      r = mk(CMD_LOOKUP, 1, pool_hash[pick], pool_tag[pick], $urandom, 0, now_t);
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80) r.expt = now_t + $urandom_range(0, 60);
      else if ($urandom_range(0, 1)) r.expt = '1;
      else r.expt = $urandom;
      if (sel < 35) r.cmd = CMD_INSERT;
      else if (sel < 60) r.cmd = CMD_LOOKUP;
      else if (sel < 72) r.cmd = CMD_CONTAINS;
      else if (sel < 84) r.cmd = CMD_REMOVE;
      else if (sel < 87) r.cmd = CMD_EVICT;
      else if (sel < 88) r.cmd = CMD_CLEAR;
      else if (sel < 90) r.cmd = $urandom_range(0, 1) ? CMD_BAD6 : CMD_BAD7;
      else begin
        r.cmd = 3'($urandom_range(0, 3));
        r.kv = 1'b0;
      end
      // occasional stranger key: a random tag with a random hash
      if ($urandom_range(0, 19) == 0) begin
        r.tag = {$urandom, $urandom};
        r.hash = $urandom;
      end
      send_plain(r);
    end
    in_if.valid <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("lru_hash_cache_with_expiry_tb: done, clean");
    end else begin
      $display("lru_hash_cache_with_expiry_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: lru_hash_cache_with_expiry.f
rtl/lhc_pkg.sv
rtl/lhc_in_if.sv
rtl/lhc_out_if.sv
rtl/lhc_ram.sv
rtl/lhc_dpath.sv
rtl/lhc_ctrl.sv
rtl/lru_hash_cache_with_expiry.sv
tb/lru_hash_cache_with_expiry_tb.sv
